### hdl/dspd_pkg.sv
package dspd_pkg;

  // Raw sample width; offsets and full-scale points share it.
  localparam int SAMPLE_BITS = 10;

  localparam int TOL_W = 7;
  localparam int AVG_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W = (SAMPLE_BITS > TOL_W) ? SAMPLE_BITS : TOL_W;

  // Scaled numerator |sample - offset| * 100 stays below 2^(SAMPLE_BITS + 7).
  localparam int PCT_SCALE = 100;
  localparam int MAG_W = SAMPLE_BITS + 7;
  localparam int PCT_W = MAG_W + 1;

  // Lane: prep stage, one stage per quotient bit, sign stage.
  localparam int LANE_STAGES = MAG_W + 2;
  localparam int MERGE_STAGES = 3;
  localparam int NUM_STAGES = LANE_STAGES + MERGE_STAGES;

  localparam int AVG_MAX = 999;

  // Reciprocal constants for the decimal split of a value below 1000.
  localparam int DIV100_MUL = 1311;
  localparam int DIV100_SHIFT = 17;
  localparam int DIV10_MUL = 103;
  localparam int DIV10_SHIFT = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_A  = 3'd0,
    CFG_FULL_A    = 3'd1,
    CFG_OFFSET_B  = 3'd2,
    CFG_FULL_B    = 3'd3,
    CFG_TOLERANCE = 3'd4
  } cfg_idx_e;

  localparam logic [SAMPLE_BITS-1:0] RST_OFFSET_A = SAMPLE_BITS'(190);
  localparam logic [SAMPLE_BITS-1:0] RST_FULL_A   = SAMPLE_BITS'(833);
  localparam logic [SAMPLE_BITS-1:0] RST_OFFSET_B = SAMPLE_BITS'(87);
  localparam logic [SAMPLE_BITS-1:0] RST_FULL_B   = SAMPLE_BITS'(413);
  localparam logic [TOL_W-1:0]       RST_TOL      = TOL_W'(10);

  localparam logic [6:0] SEG_E = 7'h06;
  localparam logic [6:0] SEG_R = 7'h2F;

  typedef struct packed {
    logic             fault;
    logic [AVG_W-1:0] average_pct;
    logic [6:0]       seg_hundreds;
    logic [6:0]       seg_tens;
    logic [6:0]       seg_units;
  } res_t;

  // Active-low segment code, bit 0 = segment a.
  function automatic logic [6:0] seg_encode(input logic [3:0] digit);
    logic [6:0] code;
    unique case (digit)
      4'd0:    code = 7'h40;
      4'd1:    code = 7'h79;
      4'd2:    code = 7'h24;
      4'd3:    code = 7'h30;
      4'd4:    code = 7'h19;
      4'd5:    code = 7'h12;
      4'd6:    code = 7'h02;
      4'd7:    code = 7'h78;
      4'd8:    code = 7'h00;
      4'd9:    code = 7'h18;
      default: code = 7'h7F;
    endcase
    return code;
  endfunction

endpackage

### hdl/dspd_ifs.sv
interface dspd_in_if;
  logic                             valid;
  logic                             ready;
  logic [dspd_pkg::SAMPLE_BITS-1:0] sample_a;
  logic [dspd_pkg::SAMPLE_BITS-1:0] sample_b;

  modport source (output valid, output sample_a, output sample_b, input ready);
  modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

interface dspd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       fault;
  logic [dspd_pkg::AVG_W-1:0] average_pct;
  logic [6:0]                 seg_hundreds;
  logic [6:0]                 seg_tens;
  logic [6:0]                 seg_units;

  modport source (output valid, output fault, output average_pct, output seg_hundreds,
                  output seg_tens, output seg_units, input ready);
  modport sink   (input valid, input fault, input average_pct, input seg_hundreds,
                  input seg_tens, input seg_units, output ready);
endinterface

### hdl/dual_sensor_plausibility_display.sv
// Plausibility check of two redundant position sensors with a three-digit
// seven-segment readout.
// Input channel in_ch carries one beat per sample pair (sample_a, sample_b).
// Output channel out_ch returns exactly one beat per pair, in order: fault,
// average_pct and three active-low segment codes (E r r on a fault).
// Calibration (offsets, full-scale points, tolerance) is written on the cfg_
// port; index 0..4 selects the register, other indexes are ignored.
// The path has one prep stage, one stage per quotient bit of the percentage
// division in each lane, a sign stage, then three merge stages that end in the
// output register. Throughput is one pair per cycle while out_ch accepts;
// each lane has its own divider pipeline.
// When out_ch stalls, pipeline stages fill up and in_ch.ready drops only once
// every stage holds a beat, so bubbles are squeezed out.
// Synchronous reset (rst_n low) empties the pipeline and loads the default
// calibration values.
module dual_sensor_plausibility_display (
  input  logic                              clk,
  input  logic                              rst_n,
  dspd_in_if.sink                           in_ch,
  dspd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [dspd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dspd_pkg::CFG_W-1:0]        cfg_data
);
  import dspd_pkg::*;

  logic [SAMPLE_BITS-1:0] offset_a_r, full_a_r, offset_b_r, full_b_r;
  logic [TOL_W-1:0]       tol_r;

  logic [NUM_STAGES-1:0]  v_r;
  logic [NUM_STAGES-1:0]  v_nxt;
  logic [NUM_STAGES-1:0]  adv;

  logic signed [PCT_W-1:0] pct_a, pct_b;
  logic                    zs_a, zs_b;
  res_t                    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_a_r <= RST_OFFSET_A;
      full_a_r   <= RST_FULL_A;
      offset_b_r <= RST_OFFSET_B;
      full_b_r   <= RST_FULL_B;
      tol_r      <= RST_TOL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_A:  offset_a_r <= cfg_data[SAMPLE_BITS-1:0];
        CFG_FULL_A:    full_a_r   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_OFFSET_B:  offset_b_r <= cfg_data[SAMPLE_BITS-1:0];
        CFG_FULL_B:    full_b_r   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_TOLERANCE: tol_r      <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or its successor advances.
  always_comb begin
    adv[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ch.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt[0] = adv[0] ? in_ch.valid : v_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_nxt[k] = adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  dspd_lane u_lane_a (
    .clk    (clk),
    .adv    (adv[LANE_STAGES-1:0]),
    .sample (in_ch.sample_a),
    .offset (offset_a_r),
    .full   (full_a_r),
    .pct    (pct_a),
    .zspan  (zs_a)
  );

  dspd_lane u_lane_b (
    .clk    (clk),
    .adv    (adv[LANE_STAGES-1:0]),
    .sample (in_ch.sample_b),
    .offset (offset_b_r),
    .full   (full_b_r),
    .pct    (pct_b),
    .zspan  (zs_b)
  );

  dspd_merge u_merge (
    .clk       (clk),
    .adv       (adv[NUM_STAGES-1:LANE_STAGES]),
    .pct_a     (pct_a),
    .pct_b     (pct_b),
    .zspan     (zs_a || zs_b),
    .tolerance (tol_r),
    .res       (res)
  );

  assign in_ch.ready         = adv[0];
  assign out_ch.valid        = v_r[NUM_STAGES-1];
  assign out_ch.fault        = res.fault;
  assign out_ch.average_pct  = res.average_pct;
  assign out_ch.seg_hundreds = res.seg_hundreds;
  assign out_ch.seg_tens     = res.seg_tens;
  assign out_ch.seg_units    = res.seg_units;

  a_fault_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.fault |-> out_ch.average_pct == '0 &&
      out_ch.seg_hundreds == SEG_E && out_ch.seg_tens == SEG_R &&
      out_ch.seg_units == SEG_R)
    else $error("fault beat without error pattern");

  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.fault |-> out_ch.average_pct <= AVG_W'(AVG_MAX))
    else $error("average out of display range");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r) && !out_ch.ready)
    else $error("input held off with a bubble in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

### hdl/dspd_lane.sv
module dspd_lane (
  input  logic                                    clk,
  input  logic [dspd_pkg::LANE_STAGES-1:0]        adv,
  input  logic [dspd_pkg::SAMPLE_BITS-1:0]        sample,
  input  logic [dspd_pkg::SAMPLE_BITS-1:0]        offset,
  input  logic [dspd_pkg::SAMPLE_BITS-1:0]        full,
  output logic signed [dspd_pkg::PCT_W-1:0]       pct,
  output logic                                    zspan
);
  import dspd_pkg::*;

  logic signed [SAMPLE_BITS:0] dnum;
  logic signed [SAMPLE_BITS:0] dspan;
  logic [SAMPLE_BITS-1:0]      anum;
  logic [SAMPLE_BITS-1:0]      aspan;
  logic [MAG_W-1:0]            num_mag;

  // Stage 0 is prep, stages 1..MAG_W each resolve one quotient bit.
  logic [MAG_W-1:0]       nq_r  [MAG_W+1];
  logic [SAMPLE_BITS-1:0] rem_r [MAG_W+1];
  logic [SAMPLE_BITS-1:0] div_r [MAG_W+1];
  logic                   neg_r [MAG_W+1];
  logic                   zs_r  [MAG_W+1];

  logic signed [PCT_W-1:0] pct_r;
  logic                    zso_r;

  assign dnum  = $signed({1'b0, sample}) - $signed({1'b0, offset});
  assign dspan = $signed({1'b0, full}) - $signed({1'b0, offset});
  assign anum  = dnum[SAMPLE_BITS] ? SAMPLE_BITS'(-dnum) : dnum[SAMPLE_BITS-1:0];
  assign aspan = dspan[SAMPLE_BITS] ? SAMPLE_BITS'(-dspan) : dspan[SAMPLE_BITS-1:0];
  assign num_mag = MAG_W'(anum) * MAG_W'(PCT_SCALE);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      nq_r[0]  <= num_mag;
      rem_r[0] <= '0;
      div_r[0] <= aspan;
      neg_r[0] <= dnum[SAMPLE_BITS] ^ dspan[SAMPLE_BITS];
      zs_r[0]  <= (aspan == '0);
    end
  end

  genvar j;
  for (j = 1; j <= MAG_W; j++) begin : g_div
    logic [SAMPLE_BITS:0] trial;
    logic [SAMPLE_BITS:0] sub;
    logic                 ge;

    assign trial = {rem_r[j-1], nq_r[j-1][MAG_W-1]};
    assign sub   = trial - {1'b0, div_r[j-1]};
    assign ge    = (trial >= {1'b0, div_r[j-1]});

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        nq_r[j]  <= {nq_r[j-1][MAG_W-2:0], ge};
        rem_r[j] <= ge ? sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
        div_r[j] <= div_r[j-1];
        neg_r[j] <= neg_r[j-1];
        zs_r[j]  <= zs_r[j-1];
      end
    end
  end

  // Apply sign: truncation toward zero is division of magnitudes.
  always_ff @(posedge clk) begin
    if (adv[MAG_W+1]) begin
      pct_r <= neg_r[MAG_W] ? -$signed({1'b0, nq_r[MAG_W]}) : $signed({1'b0, nq_r[MAG_W]});
      zso_r <= zs_r[MAG_W];
    end
  end

  assign pct   = pct_r;
  assign zspan = zso_r;

endmodule

### hdl/dspd_merge.sv
module dspd_merge (
  input  logic                                  clk,
  input  logic [dspd_pkg::MERGE_STAGES-1:0]     adv,
  input  logic signed [dspd_pkg::PCT_W-1:0]     pct_a,
  input  logic signed [dspd_pkg::PCT_W-1:0]     pct_b,
  input  logic                                  zspan,
  input  logic [dspd_pkg::TOL_W-1:0]            tolerance,
  output dspd_pkg::res_t                        res
);
  import dspd_pkg::*;

  logic signed [PCT_W:0]   diff;
  logic [PCT_W:0]          adiff;
  logic signed [PCT_W:0]   sum;
  logic signed [PCT_W:0]   avg;
  logic                    bad;

  logic                    f1_r;
  logic [AVG_W-1:0]        avg1_r;

  logic [AVG_W+10:0]       hprod;
  logic [3:0]              hund;
  logic [AVG_W-1:0]        hrem;
  logic                    f2_r;
  logic [AVG_W-1:0]        avg2_r;
  logic [3:0]              hund2_r;
  logic [6:0]              rem2_r;

  logic [13:0]             tprod;
  logic [3:0]              tens;
  logic [6:0]              urem;
  res_t                    res_r;

  // Stage 1: agreement check and average.
  assign diff  = $signed({pct_a[PCT_W-1], pct_a}) - $signed({pct_b[PCT_W-1], pct_b});
  assign adiff = diff[PCT_W] ? (PCT_W+1)'(-diff) : diff;
  assign sum   = $signed({pct_a[PCT_W-1], pct_a}) + $signed({pct_b[PCT_W-1], pct_b});
  // Round a negative half toward zero.
  assign avg   = (sum + $signed({{PCT_W{1'b0}}, sum[PCT_W]})) >>> 1;
  assign bad   = zspan || (adiff >= (PCT_W+1)'(tolerance)) || avg[PCT_W]
                 || (avg > $signed((PCT_W+1)'(AVG_MAX)));

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      f1_r   <= bad;
      avg1_r <= bad ? '0 : avg[AVG_W-1:0];
    end
  end

  // Stage 2: hundreds digit by reciprocal multiply.
  assign hprod = (AVG_W+11)'(avg1_r) * (AVG_W+11)'(DIV100_MUL);
  assign hund  = hprod[DIV100_SHIFT +: 4];
  assign hrem  = avg1_r - AVG_W'(hund) * AVG_W'(100);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      f2_r    <= f1_r;
      avg2_r  <= avg1_r;
      hund2_r <= hund;
      rem2_r  <= hrem[6:0];
    end
  end

  // Stage 3: tens and units, segment codes.
  assign tprod = 14'(rem2_r) * 14'(DIV10_MUL);
  assign tens  = tprod[DIV10_SHIFT +: 4];
  assign urem  = rem2_r - 7'(tens) * 7'(10);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      res_r.fault       <= f2_r;
      res_r.average_pct <= avg2_r;
      if (f2_r) begin
        res_r.seg_hundreds <= SEG_E;
        res_r.seg_tens     <= SEG_R;
        res_r.seg_units    <= SEG_R;
      end else begin
        res_r.seg_hundreds <= seg_encode(hund2_r);
        res_r.seg_tens     <= seg_encode(tens);
        res_r.seg_units    <= seg_encode(urem[3:0]);
      end
    end
  end

  assign res = res_r;

endmodule

### tb/tb_dual_sensor_plausibility_display.sv
module tb_dual_sensor_plausibility_display;
  import dspd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASES = 10;
  localparam int PAIRS_PER_PHASE = 55;
  localparam int RAW_MAX = (1 << SAMPLE_BITS) - 1;
  localparam logic [CFG_IDX_W-1:0] NO_REG = CFG_IDX_W'(CFG_TOLERANCE + 1);

  // Digit d sits in slice d: active-low codes for 0..9.
  localparam logic [9:0][6:0] SEVEN_SEG = {7'h18, 7'h00, 7'h78, 7'h02, 7'h12,
                                           7'h19, 7'h30, 7'h24, 7'h79, 7'h40};

  localparam res_t SHOW_ERR = '{1'b1, 10'd0, SEG_E, SEG_R, SEG_R};
  localparam res_t SHOW_0   = '{1'b0, 10'd0, 7'h40, 7'h40, 7'h40};
  localparam res_t SHOW_100 = '{1'b0, 10'd100, 7'h79, 7'h40, 7'h40};
  localparam res_t SHOW_888 = '{1'b0, 10'd888, 7'h00, 7'h00, 7'h00};
  localparam res_t SHOW_999 = '{1'b0, 10'd999, 7'h18, 7'h18, 7'h18};

  typedef struct {
    bit                     is_write;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_W-1:0]       reg_val;
    logic [SAMPLE_BITS-1:0] sa;
    logic [SAMPLE_BITS-1:0] sb;
    bit                     typed;
    res_t                   want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dspd_in_if  in_ch ();
  dspd_out_if out_ch ();

  dual_sensor_plausibility_display dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Calibration as the block should hold it.
  logic [SAMPLE_BITS-1:0] cal_off_a, cal_full_a, cal_off_b, cal_full_b;
  logic [TOL_W-1:0] cal_tol;

  res_t pending_displays[$];
  dir_row_t dir_rows[$];
  int fails = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;
  bit hold_off_req = 1'b0;

  function automatic res_t expected_display(logic [SAMPLE_BITS-1:0] sa,
                                            logic [SAMPLE_BITS-1:0] sb);
    longint off_a, off_b, span_a, span_b, pa, pb, diff, avg;
    bit ok;
    res_t r;
    off_a = cal_off_a;
    off_b = cal_off_b;
    span_a = longint'(cal_full_a) - off_a;
    span_b = longint'(cal_full_b) - off_b;
    ok = (span_a != 0) && (span_b != 0);
    pa = 0;
    pb = 0;
    avg = 0;
    if (ok) begin
      pa = ((longint'(sa) - off_a) * 100) / span_a;
      pb = ((longint'(sb) - off_b) * 100) / span_b;
      diff = (pa > pb) ? pa - pb : pb - pa;
      if (diff >= longint'(cal_tol)) ok = 1'b0;
    end
    if (ok) begin
      avg = (pa + pb) / 2;
      if (avg < 0 || avg > AVG_MAX) ok = 1'b0;
    end
    if (ok) begin
      r.fault = 1'b0;
      r.average_pct = AVG_W'(avg);
      r.seg_hundreds = SEVEN_SEG[int'((avg / 100) % 10)];
      r.seg_tens = SEVEN_SEG[int'((avg / 10) % 10)];
      r.seg_units = SEVEN_SEG[int'(avg % 10)];
    end else begin
      r = SHOW_ERR;
    end
    return r;
  endfunction

  // Raw reading that lands near a given percentage, with a little noise.
  function automatic logic [SAMPLE_BITS-1:0] raw_for(int pct, logic [SAMPLE_BITS-1:0] off,
                                                     logic [SAMPLE_BITS-1:0] full);
    int raw;
    raw = int'(off) + pct * (int'(full) - int'(off)) / 100 + int'($urandom_range(4, 0)) - 2;
    if (raw < 0) raw = 0;
    else if (raw > RAW_MAX) raw = RAW_MAX;
    return raw[SAMPLE_BITS-1:0];
  endfunction

  function automatic int idle_draw();
    return steady ? 0 : int'($urandom_range(10, 0));
  endfunction

  function automatic dir_row_t w_row(logic [CFG_IDX_W-1:0] idx, int val);
    dir_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.reg_idx = idx;
    r.reg_val = CFG_W'(val);
    return r;
  endfunction

  function automatic dir_row_t p_row(int sa, int sb);
    dir_row_t r;
    r = '{default: '0};
    r.sa = SAMPLE_BITS'(sa);
    r.sb = SAMPLE_BITS'(sb);
    return r;
  endfunction

  function automatic dir_row_t t_row(int sa, int sb, res_t want);
    dir_row_t r;
    r = p_row(sa, sb);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  task automatic send_pair(logic [SAMPLE_BITS-1:0] sa, logic [SAMPLE_BITS-1:0] sb,
                           bit typed, res_t want);
    res_t exp_r;
    exp_r = typed ? want : expected_display(sa, sb);
    repeat (idle_draw()) @(negedge clk) in_ch.valid <= 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.sample_a <= sa;
    in_ch.sample_b <= sb;
    do @(posedge clk); while (!in_ch.ready);
    pending_displays.push_back(exp_r);
  endtask

  // Drop valid and hold until every outstanding beat has come back.
  task automatic settle();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
  endtask

  task automatic cal_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_OFFSET_A:  cal_off_a = val[SAMPLE_BITS-1:0];
      CFG_FULL_A:    cal_full_a = val[SAMPLE_BITS-1:0];
      CFG_OFFSET_B:  cal_off_b = val[SAMPLE_BITS-1:0];
      CFG_FULL_B:    cal_full_b = val[SAMPLE_BITS-1:0];
      CFG_TOLERANCE: cal_tol = val[TOL_W-1:0];
      default: ;
    endcase
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        stall = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        stall = idle_draw();
      end
      repeat (stall) @(negedge clk) out_ch.ready <= 1'b0;
      @(negedge clk) out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_displays.size() == 0) begin
        $error("unexpected result beat: fault %0d avg %0d", out_ch.fault, out_ch.average_pct);
        fails++;
      end else begin
        want = pending_displays.pop_front();
        if (out_ch.fault !== want.fault) begin
          $error("fault: expected %0d, got %0d", want.fault, out_ch.fault);
          fails++;
        end
        if (out_ch.average_pct !== want.average_pct) begin
          $error("average_pct: expected %0d, got %0d", want.average_pct, out_ch.average_pct);
          fails++;
        end
        if (out_ch.seg_hundreds !== want.seg_hundreds) begin
          $error("seg_hundreds: expected %h, got %h", want.seg_hundreds, out_ch.seg_hundreds);
          fails++;
        end
        if (out_ch.seg_tens !== want.seg_tens) begin
          $error("seg_tens: expected %h, got %h", want.seg_tens, out_ch.seg_tens);
          fails++;
        end
        if (out_ch.seg_units !== want.seg_units) begin
          $error("seg_units: expected %h, got %h", want.seg_units, out_ch.seg_units);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[dual_sensor_plausibility_display] ERROR");
      $finish;
    end
  end

  initial begin
    int mode;
    int pct;
    logic [SAMPLE_BITS-1:0] oa, fa, ob, fb, sa, sb;
    logic [CFG_W-1:0] tol_val;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_a = '0;
    in_ch.sample_b = '0;
    out_ch.ready = 1'b0;
    cal_off_a = RST_OFFSET_A;
    cal_full_a = RST_FULL_A;
    cal_off_b = RST_OFFSET_B;
    cal_full_b = RST_FULL_B;
    cal_tol = RST_TOL;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset calibration, extremes, then each corner of the scaling.
    dir_rows.push_back(t_row(190, 87, SHOW_0));
    dir_rows.push_back(t_row(833, 413, SHOW_100));
    dir_rows.push_back(t_row(0, 1023, SHOW_ERR));
    dir_rows.push_back(p_row(1023, 1023));
    dir_rows.push_back(p_row(0, 0));
    dir_rows.push_back(p_row('h2AA, 'h155));
    dir_rows.push_back(p_row('h155, 'h2AA));
    dir_rows.push_back(w_row(CFG_TOLERANCE, 0));
    dir_rows.push_back(t_row(190, 87, SHOW_ERR));
    dir_rows.push_back(w_row(CFG_TOLERANCE, 'h3FF));
    dir_rows.push_back(p_row(1023, 1023));
    dir_rows.push_back(p_row(833, 413));
    dir_rows.push_back(w_row(CFG_FULL_A, 190));
    dir_rows.push_back(t_row(190, 87, SHOW_ERR));
    // reversed span on A, full range on B
    dir_rows.push_back(w_row(CFG_OFFSET_A, 1023));
    dir_rows.push_back(w_row(CFG_FULL_A, 0));
    dir_rows.push_back(w_row(CFG_OFFSET_B, 0));
    dir_rows.push_back(w_row(CFG_FULL_B, 1023));
    dir_rows.push_back(t_row(0, 1023, SHOW_100));
    dir_rows.push_back(p_row(1023, 0));
    dir_rows.push_back(p_row(512, 511));
    dir_rows.push_back(w_row(NO_REG, 0));
    dir_rows.push_back(p_row(0, 1023));
    // unit scale: percent equals raw, so the average can pass 999
    dir_rows.push_back(w_row(CFG_OFFSET_A, 0));
    dir_rows.push_back(w_row(CFG_FULL_A, 100));
    dir_rows.push_back(w_row(CFG_FULL_B, 100));
    dir_rows.push_back(t_row(999, 999, SHOW_999));
    dir_rows.push_back(t_row(1000, 1000, SHOW_ERR));
    dir_rows.push_back(t_row(888, 888, SHOW_888));
    dir_rows.push_back(p_row(1023, 0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_write) begin
        settle();
        cal_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_pair(dir_rows[i].sa, dir_rows[i].sb, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      mode = ph % 5;
      case (mode)
        0: begin
          oa = SAMPLE_BITS'($urandom_range(400, 0));
          fa = SAMPLE_BITS'($urandom_range(RAW_MAX, oa + 200));
          ob = SAMPLE_BITS'($urandom_range(400, 0));
          fb = SAMPLE_BITS'($urandom_range(RAW_MAX, ob + 150));
          tol_val = CFG_W'($urandom_range(30, 1));
        end
        1: begin
          oa = SAMPLE_BITS'($urandom_range(RAW_MAX, 600));
          fa = SAMPLE_BITS'($urandom_range(oa - 200, 0));
          ob = SAMPLE_BITS'($urandom_range(RAW_MAX, 600));
          fb = SAMPLE_BITS'($urandom_range(ob - 200, 0));
          tol_val = CFG_W'($urandom_range(100, 5));
        end
        2: begin
          oa = '0;
          fa = SAMPLE_BITS'(RAW_MAX);
          ob = SAMPLE_BITS'(RAW_MAX);
          fb = '0;
          tol_val = CFG_W'(100);
        end
        3: begin
          oa = SAMPLE_BITS'($urandom_range(RAW_MAX, 0));
          fa = SAMPLE_BITS'($urandom_range(RAW_MAX, 0));
          ob = SAMPLE_BITS'($urandom_range(RAW_MAX, 0));
          fb = SAMPLE_BITS'($urandom_range(RAW_MAX, 0));
          if ($urandom_range(1, 0) == 0) fa = oa;
          tol_val = CFG_W'($urandom_range(RAW_MAX, 0));
        end
        default: begin
          oa = SAMPLE_BITS'($urandom_range(1000, 0));
          fa = SAMPLE_BITS'(oa + $urandom_range(20, 1));
          ob = SAMPLE_BITS'($urandom_range(1000, 0));
          fb = SAMPLE_BITS'(ob + $urandom_range(20, 1));
          tol_val = CFG_W'($urandom_range(127, 20));
        end
      endcase
      cal_write(CFG_OFFSET_A, oa);
      cal_write(CFG_FULL_A, fa);
      cal_write(CFG_OFFSET_B, ob);
      cal_write(CFG_FULL_B, fb);
      cal_write(CFG_TOLERANCE, tol_val);
      cal_write(NO_REG + CFG_IDX_W'($urandom_range(2, 0)), CFG_W'($urandom_range(RAW_MAX, 0)));

      steady = (ph == 2) || (ph == 3) || (ph == 7);
      // fill the pipeline against a stalled receiver
      if (ph == 3) hold_off_req = 1'b1;

      for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
        if ($urandom_range(3, 0) != 0) begin
          pct = int'($urandom_range(120, 0)) - 10;
          sa = raw_for(pct, cal_off_a, cal_full_a);
          sb = raw_for(pct, cal_off_b, cal_full_b);
        end else begin
          sa = SAMPLE_BITS'($urandom_range(RAW_MAX, 0));
          sb = SAMPLE_BITS'($urandom_range(RAW_MAX, 0));
        end
        send_pair(sa, sb, 1'b0, SHOW_ERR);
      end
    end
    steady = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("[dual_sensor_plausibility_display] OK");
    end else begin
      $display("[dual_sensor_plausibility_display] ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/dspd_pkg.sv
hdl/dspd_ifs.sv
hdl/dspd_lane.sv
hdl/dspd_merge.sv
hdl/dual_sensor_plausibility_display.sv
tb/tb_dual_sensor_plausibility_display.sv
